[rtl/acfe_pkg.sv]
// Package for the audio chunk feature extractor.
// Holds sizes, register indexes, the sequencer and serial-unit types.
// No dependencies.
package acfe_pkg;

  localparam int MAX_CHUNK_SAMPLES = 4096;
  localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEFS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_COEFS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_EN   = 3'd5;

  localparam logic [15:0] ONE_Q15      = 16'd32768;
  localparam logic [17:0] BASELINE_Q15 = 18'd13107;
  localparam logic [16:0] LERP_Q15     = 17'd4915;

  // serial unit step counts (one bit or one radix-4 digit per cycle)
  localparam logic [5:0] MUL_STEPS  = 6'd17;
  localparam logic [5:0] DIV_STEPS  = 6'd48;
  localparam logic [5:0] SQRT_STEPS = 6'd16;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic        neg;
    logic [47:0] a;
    logic [17:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [50:0] value;
  } arith_rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

  typedef enum logic [4:0] {
    SP_SQ, SP_BX, SP_A1, SP_A2, SP_OO,
    SP_DIV_E, SP_RMS, SP_ZCR, SP_OPEN, SP_WIDE,
    SP_DIV_B, SP_BAND_RMS, SP_LR, SP_HR,
    SP_SL, SP_FUN, SP_SH, SP_FRIC, SP_SLOW
  } step_t;

endpackage

[rtl/acfe_if.sv]
// Channel interfaces of the audio chunk feature extractor.
// Depends on acfe_pkg for the configuration index width.
interface acfe_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_in_chunk;
  modport source (output valid, sample, last_in_chunk, input ready);
  modport sink (input valid, sample, last_in_chunk, output ready);
endinterface

interface acfe_feature_if;
  logic        valid;
  logic        ready;
  logic [15:0] open_target;
  logic [15:0] wide_target;
  logic [15:0] funnel_target;
  logic [15:0] fricative_target;
  logic        plosive_onset;
  modport source (output valid, open_target, wide_target, funnel_target,
                  fricative_target, plosive_onset, input ready);
  modport sink (input valid, open_target, wide_target, funnel_target,
                fricative_target, plosive_onset, output ready);
endinterface

interface acfe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [acfe_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/audio_chunk_feature_extractor_core.sv]
// Audio chunk feature extractor: energy, crossings, three band-pass biquads,
// RMS-based mouth targets and plosive onset. Depends on acfe_pkg, acfe_if
// and acfe_serial_unit.
//
//   channel   dir  payload                                  transaction
//   samples   in   sample, last_in_chunk                    valid & ready
//   features  out  open/wide/funnel/fricative, onset        valid & ready
//   cfg       in   index, data                              valid & ready
//
// One shared serial unit does every multiply, divide and square root; each
// operation is issued, waited for and then written back.
// A sample takes a squaring multiply, plus biquad multiplies with bands enabled.
// Chunk end runs the RMS and target steps, plus band steps when enabled.
// Reset is synchronous and clears all chunk, filter and level state.
// A pending result stalls only the finish of the next chunk, not its samples.
module audio_chunk_feature_extractor_core (
  input logic            clk,
  input logic            rst,
  acfe_sample_if.sink    samples,
  acfe_feature_if.source features,
  acfe_cfg_if.sink       cfg
);
  import acfe_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;
  logic [1:0] bnd, bnd_next;

  arith_req_t req;
  arith_rsp_t rsp;

  logic [47:0] coef [3];
  logic [63:0] gains;
  logic [31:0] thresh;
  logic        multi;

  logic signed [31:0] z0 [3];
  logic signed [31:0] z1 [3];
  logic [47:0]        esum [4];
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   ccount;
  logic               prev_sign;
  logic               chunk_end;
  logic [15:0]        slow;

  logic signed [15:0] xs;
  logic signed [31:0] bx;
  logic signed [31:0] y;
  logic [31:0]        q;
  logic [15:0]        rms, zcr, open_t, wide_t, lr, hr, sl, sh, funnel, fric;
  logic [15:0]        brms [3];
  logic               onset;

  logic        out_valid;
  logic [15:0] out_open, out_wide, out_funnel, out_fric;
  logic        out_onset;

  logic signed [50:0] p, p5, p14, p15;
  logic signed [31:0] bx_w, yo;
  logic signed [15:0] o;
  logic [17:0]        total;
  logic signed [17:0] d_l, d_h, jump;
  logic [19:0]        rms12;
  logic [16:0]        rms12_sat;
  logic               fin_sample, out_free, clear_chunk, in_acc;
  logic [1:0]         bnd_e;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(~e + 17'd1) : e;
  endfunction

  function automatic logic [32:0] abs32(input logic signed [31:0] v);
    logic [32:0] e;
    e = {v[31], v};
    return v[31] ? 33'(~e + 33'd1) : e;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7fffffff;
    if (v < -51'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [47:0] acc48(input logic [47:0] s, input logic [30:0] a);
    logic [48:0] t;
    t = {1'b0, s} + 49'(a);
    return t[48] ? '1 : t[47:0];
  endfunction

  function automatic logic [15:0] sat_one(input logic [41:0] v);
    return (v > 42'(ONE_Q15)) ? ONE_Q15 : v[15:0];
  endfunction

  acfe_serial_unit u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // datapath views
  assign p     = $signed(rsp.value);
  assign p5    = p >>> 5;
  assign p14   = p >>> 14;
  assign p15   = p >>> 15;
  assign bx_w  = p5[31:0];
  assign yo    = y >>> 9;
  assign o     = (yo > 32'sd32767) ? 16'sh7fff :
                 (yo < -32'sd32768) ? 16'sh8000 : yo[15:0];
  assign total = 18'(brms[0]) + 18'(brms[1]) + 18'(brms[2]);
  assign d_l   = $signed({2'b00, lr} - BASELINE_Q15);
  assign d_h   = $signed({2'b00, hr} - BASELINE_Q15);
  assign jump  = $signed({2'b00, rms} - {2'b00, slow});
  assign rms12 = {1'b0, rms, 3'b000} + {2'b00, rms, 2'b00};
  assign rms12_sat = (rms12 > 20'(ONE_Q15)) ? 17'(ONE_Q15) : rms12[16:0];
  assign bnd_e = 2'(bnd + 2'd1);

  assign in_acc     = samples.valid && samples.ready;
  assign fin_sample = (step == SP_SQ && !multi) || (step == SP_OO && bnd == 2'd2);
  assign out_free   = !out_valid || features.ready;

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    bnd_next   = bnd;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_ISSUE;
          step_next  = SP_SQ;
          bnd_next   = 2'd0;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) begin
          state_next = ST_ISSUE;
          if (fin_sample) begin
            if (!chunk_end || cnt <= CNT_W'(1)) state_next = ST_IDLE;
            else step_next = SP_DIV_E;
          end else begin
            case (step)
              SP_SQ: begin
                step_next = SP_BX;
                bnd_next  = 2'd0;
              end
              SP_BX: step_next = SP_A1;
              SP_A1: step_next = SP_A2;
              SP_A2: step_next = SP_OO;
              SP_OO: begin
                step_next = SP_BX;
                bnd_next  = 2'(bnd + 2'd1);
              end
              SP_DIV_E: step_next = SP_RMS;
              SP_RMS:   step_next = SP_ZCR;
              SP_ZCR:   step_next = SP_OPEN;
              SP_OPEN:  step_next = SP_WIDE;
              SP_WIDE: begin
                if (multi) begin
                  step_next = SP_DIV_B;
                  bnd_next  = 2'd0;
                end else begin
                  state_next = ST_OUT;
                end
              end
              SP_DIV_B: step_next = SP_BAND_RMS;
              SP_BAND_RMS: begin
                if (bnd == 2'd2) begin
                  step_next = SP_LR;
                end else begin
                  step_next = SP_DIV_B;
                  bnd_next  = 2'(bnd + 2'd1);
                end
              end
              SP_LR:   step_next = SP_HR;
              SP_HR:   step_next = SP_SL;
              SP_SL:   step_next = SP_FUN;
              SP_FUN:  step_next = SP_SH;
              SP_SH:   step_next = SP_FRIC;
              SP_FRIC: step_next = SP_SLOW;
              default: state_next = ST_OUT;
            endcase
          end
        end
      end
      default: begin
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // outputs: handshakes and serial-unit operands
  always_comb begin
    samples.ready = (state == ST_IDLE);
    cfg.ready     = 1'b1;
    clear_chunk   = (state == ST_OUT && out_free) ||
                    (state == ST_WAIT && rsp.done && fin_sample && chunk_end &&
                     cnt <= CNT_W'(1));
    req.start = (state == ST_ISSUE);
    req.op    = OP_MUL;
    req.neg   = 1'b0;
    req.a     = '0;
    req.b     = '0;
    case (step)
      SP_SQ: begin
        req.a = 48'(abs16(xs));
        req.b = 18'(abs16(xs));
      end
      SP_BX: begin
        req.a   = 48'(abs16(xs));
        req.b   = 18'(abs16(coef[bnd][15:0]));
        req.neg = xs[15] ^ coef[bnd][15];
      end
      SP_A1: begin
        req.a   = 48'(abs32(y));
        req.b   = 18'(abs16(coef[bnd][31:16]));
        req.neg = y[31] ^ coef[bnd][31];
      end
      SP_A2: begin
        req.a   = 48'(abs32(y));
        req.b   = 18'(abs16(coef[bnd][47:32]));
        req.neg = y[31] ^ coef[bnd][47];
      end
      SP_OO: begin
        req.a = 48'(abs16(o));
        req.b = 18'(abs16(o));
      end
      SP_DIV_E: begin
        req.op = OP_DIV;
        req.a  = esum[0];
        req.b  = 18'(cnt);
      end
      SP_RMS, SP_BAND_RMS: begin
        req.op = OP_SQRT;
        req.a  = 48'(q);
      end
      SP_ZCR: begin
        req.op = OP_DIV;
        req.a  = 48'({ccount, 15'b0});
        req.b  = 18'(cnt);
      end
      SP_OPEN: begin
        req.a = 48'(rms);
        req.b = 18'(gains[15:0]);
      end
      SP_WIDE: begin
        req.a = 48'(zcr);
        req.b = 18'(gains[31:16]);
      end
      SP_DIV_B: begin
        req.op = OP_DIV;
        req.a  = esum[bnd_e];
        req.b  = 18'(cnt);
      end
      SP_LR: begin
        req.op = OP_DIV;
        req.a  = 48'({brms[0], 15'b0});
        req.b  = total;
      end
      SP_HR: begin
        req.op = OP_DIV;
        req.a  = 48'({brms[2], 15'b0});
        req.b  = total;
      end
      SP_SL: begin
        req.a = (d_l > 18'sd0) ? 48'(d_l[15:0]) : '0;
        req.b = 18'(gains[47:32]);
      end
      SP_FUN: begin
        req.a = 48'(sl);
        req.b = 18'(open_t);
      end
      SP_SH: begin
        req.a = (d_h > 18'sd0) ? 48'(d_h[15:0]) : '0;
        req.b = 18'(gains[63:48]);
      end
      SP_FRIC: begin
        req.a = 48'(sh);
        req.b = 18'(rms12_sat);
      end
      default: begin
        req.a   = 48'(abs16(jump[15:0] == 16'h8000 && !jump[17] ? 16'sh7fff : jump[15:0]));
        req.neg = jump[17];
        if (jump == 18'sd32768) req.a = 48'd32768;
        req.b   = 18'(LERP_Q15);
      end
    endcase
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= SP_SQ;
      bnd       <= 2'd0;
      gains     <= '0;
      thresh    <= '0;
      multi     <= 1'b1;
      cnt       <= '0;
      ccount    <= '0;
      prev_sign <= 1'b0;
      chunk_end <= 1'b0;
      slow      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        coef[i] <= '0;
        z0[i]   <= '0;
        z1[i]   <= '0;
      end
      for (int i = 0; i < 4; i++) esum[i] <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      bnd   <= bnd_next;

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LOW_COEFS, REG_MID_COEFS, REG_HIGH_COEFS: begin
            coef[cfg.index[1:0]] <= cfg.data[47:0];
            z0[cfg.index[1:0]]   <= '0;
            z1[cfg.index[1:0]]   <= '0;
          end
          REG_GAINS:    gains  <= cfg.data;
          REG_THRESH:   thresh <= cfg.data[31:0];
          REG_MULTI_EN: multi  <= cfg.data[0];
          default: ;
        endcase
      end

      if (in_acc) begin
        if (cnt != '0 && (!samples.sample[15]) != prev_sign)
          ccount <= CNT_W'(ccount + 1'b1);
        prev_sign <= !samples.sample[15];
        cnt       <= CNT_W'(cnt + 1'b1);
        chunk_end <= samples.last_in_chunk ||
                     (CNT_W'(cnt + 1'b1) == CNT_W'(MAX_CHUNK_SAMPLES));
      end

      if (state == ST_WAIT && rsp.done) begin
        case (step)
          SP_SQ: esum[0] <= acc48(esum[0], p[30:0]);
          SP_A1: z0[bnd] <= sat32(51'(z1[bnd]) - p14);
          SP_A2: z1[bnd] <= sat32(-51'(bx) - p14);
          SP_OO: esum[bnd_e] <= acc48(esum[bnd_e], p[30:0]);
          SP_SLOW: slow <= 16'(slow + p15[15:0]);
          default: ;
        endcase
      end

      if (clear_chunk) begin
        for (int i = 0; i < 4; i++) esum[i] <= '0;
        cnt       <= '0;
        ccount    <= '0;
        prev_sign <= 1'b0;
      end

      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (features.valid && features.ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) xs <= samples.sample;
    if (state == ST_WAIT && rsp.done) begin
      case (step)
        SP_BX: begin
          bx <= bx_w;
          y  <= sat32(51'(bx_w) + 51'(z0[bnd]));
        end
        SP_DIV_E, SP_DIV_B: q <= rsp.value[31:0];
        SP_RMS:      rms <= rsp.value[15:0];
        SP_BAND_RMS: brms[bnd] <= rsp.value[15:0];
        SP_ZCR:      zcr <= rsp.value[15:0];
        SP_OPEN:     open_t <= sat_one(rsp.value[49:8]);
        SP_WIDE:     wide_t <= sat_one(rsp.value[49:8]);
        SP_LR:       lr <= (total == '0) ? '0 : rsp.value[15:0];
        SP_HR:       hr <= (total == '0) ? '0 : rsp.value[15:0];
        SP_SL:       sl <= sat_one(rsp.value[49:8]);
        SP_SH:       sh <= sat_one(rsp.value[49:8]);
        SP_FUN:      funnel <= rsp.value[30:15];
        SP_FRIC:     fric <= rsp.value[30:15];
        SP_SLOW: begin
          onset <= (slow < thresh[15:0]) && (jump > $signed({2'b00, thresh[31:16]}));
        end
        default: ;
      endcase
    end
    if (state == ST_OUT && out_free) begin
      out_open   <= open_t;
      out_wide   <= wide_t;
      out_funnel <= multi ? funnel : '0;
      out_fric   <= multi ? fric : '0;
      out_onset  <= multi && onset;
    end
  end

  assign features.valid            = out_valid;
  assign features.open_target      = out_open;
  assign features.wide_target      = out_wide;
  assign features.funnel_target    = out_funnel;
  assign features.fricative_target = out_fric;
  assign features.plosive_onset    = out_onset;

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == ST_WAIT)
    else $error("serial unit finished outside the wait state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> cnt < CNT_W'(MAX_CHUNK_SAMPLES))
    else $error("sample accepted with a full chunk");

  a_targets_bounded: assert property (@(posedge clk) disable iff (rst)
    features.valid |-> (features.open_target <= ONE_Q15) &&
                       (features.wide_target <= ONE_Q15) &&
                       (features.funnel_target <= ONE_Q15) &&
                       (features.fricative_target <= ONE_Q15))
    else $error("target above 1.0");

endmodule

[rtl/acfe_serial_unit.sv]
// Shared serial arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root. Depends on acfe_pkg.
module acfe_serial_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  acfe_pkg::arith_req_t req,
  output acfe_pkg::arith_rsp_t rsp
);
  import acfe_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [5:0]  steps;
  arith_op_t   op;
  logic        neg;
  logic [49:0] acc;
  logic [49:0] mcand;
  logic [16:0] mplier;
  logic [47:0] num;
  logic [17:0] rem;
  logic [17:0] den;
  logic [31:0] rad;
  logic [17:0] srem;
  logic [15:0] root;
  logic [18:0] rem_sh;
  logic [19:0] srem_sh;
  logic [19:0] trial;

  always_comb begin
    case (req.op)
      OP_MUL:  steps = MUL_STEPS;
      OP_DIV:  steps = DIV_STEPS;
      default: steps = SQRT_STEPS;
    endcase
  end

  assign rem_sh  = {rem, num[47]};
  assign srem_sh = {srem, rad[31:30]};
  assign trial   = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= steps - 6'd1;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op     <= req.op;
      neg    <= req.neg;
      acc    <= '0;
      mcand  <= {17'b0, req.a[32:0]};
      mplier <= req.b[16:0];
      num    <= req.a;
      rem    <= '0;
      den    <= req.b;
      rad    <= req.a[31:0];
      srem   <= '0;
      root   <= '0;
    end else if (busy) begin
      case (op)
        OP_MUL: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= {mcand[48:0], 1'b0};
          mplier <= {1'b0, mplier[16:1]};
        end
        OP_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= 18'(rem_sh - {1'b0, den});
            num <= {num[46:0], 1'b1};
          end else begin
            rem <= rem_sh[17:0];
            num <= {num[46:0], 1'b0};
          end
        end
        default: begin
          rad <= {rad[29:0], 2'b00};
          if (srem_sh >= trial) begin
            srem <= 18'(srem_sh - trial);
            root <= {root[14:0], 1'b1};
          end else begin
            srem <= srem_sh[17:0];
            root <= {root[14:0], 1'b0};
          end
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = done;
    case (op)
      OP_MUL:  rsp.value = neg ? 51'(-{1'b0, acc}) : {1'b0, acc};
      OP_DIV:  rsp.value = {3'b0, num};
      default: rsp.value = {35'b0, root};
    endcase
  end

endmodule

[tb/sv/audio_chunk_feature_extractor_core_tb.sv]
// Testbench for audio_chunk_feature_extractor_core: drives sample chunks and
// register writes, predicts each chunk's feature result and checks it.
// Depends on acfe_pkg, acfe_if and the core RTL.
`timescale 1ns / 100ps

module audio_chunk_feature_extractor_core_tb;
  import acfe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int SETTLE_CYCLES = 700;

  typedef struct packed {
    logic [15:0] open_target;
    logic [15:0] wide_target;
    logic [15:0] funnel_target;
    logic [15:0] fricative_target;
    logic        plosive_onset;
  } feature_t;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               lst;
    logic               typed;
    feature_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  acfe_sample_if  s_if();
  acfe_feature_if f_if();
  acfe_cfg_if     c_if();

  audio_chunk_feature_extractor_core uut (
    .clk(clk), .rst(rst), .samples(s_if), .features(f_if), .cfg(c_if)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // predictor state
  logic [47:0] band_coef[3];
  logic [63:0] gain_word;
  logic [31:0] thresh_word;
  logic        bands_on;
  longint      delay_line[6];
  longint      energy[4];
  longint      crossings, n_samples, slow_level;
  logic        was_positive;

  feature_t feature_q[$];
  int       err_cnt = 0;
  int       hold_cycles = 0;
  int       ready_mode = 0;
  int       burst_left = 0;
  logic     long_hold_done = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_one(longint v);
    return (v > 32768) ? 32768 : v;
  endfunction

  function automatic longint add48(longint s, longint a);
    longint t;
    t = s + a;
    return (t > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : t;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 40;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint gain_field(int pos);
    return longint'(gain_word[pos +: 16]);
  endfunction

  function automatic longint shape_ratio(longint ratio, longint gain);
    longint d;
    d = ratio - 13107;
    if (d <= 0) return 0;
    return sat_one((d * gain) >>> 8);
  endfunction

  function automatic longint run_biquad(int b, longint x);
    longint b0, a1, a2, bx, y, o;
    b0 = longint'($signed(band_coef[b][15:0]));
    a1 = longint'($signed(band_coef[b][31:16]));
    a2 = longint'($signed(band_coef[b][47:32]));
    bx = (b0 * x) >>> 5;
    y = sat32(bx + delay_line[2*b]);
    delay_line[2*b] = sat32(delay_line[2*b+1] - ((a1 * y) >>> 14));
    delay_line[2*b+1] = sat32(-bx - ((a2 * y) >>> 14));
    o = y >>> 9;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o;
  endfunction

  function automatic void clear_chunk();
    for (int i = 0; i < 4; i++) energy[i] = 0;
    crossings = 0;
    n_samples = 0;
    was_positive = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
    case (idx)
      REG_LOW_COEFS, REG_MID_COEFS, REG_HIGH_COEFS: begin
        band_coef[idx] = d[47:0];
        delay_line[2*idx] = 0;
        delay_line[2*idx+1] = 0;
      end
      REG_GAINS: gain_word = d;
      REG_THRESH: thresh_word = d[31:0];
      REG_MULTI_EN: bands_on = d[0];
      default: ;
    endcase
  endfunction

  // advance the chunk by one sample; returns 1 with the features at chunk end
  function automatic logic chunk_features(logic signed [15:0] smp, logic lst,
                                          output feature_t f);
    longint x, o, rms, zcr, opn, lo, mid, hi, tot, lr, hr, jump;
    logic pos;
    x = longint'(smp);
    pos = (x >= 0);
    f = '0;
    energy[0] = add48(energy[0], x * x);
    if (n_samples > 0 && pos != was_positive) crossings++;
    was_positive = pos;
    n_samples++;
    if (bands_on) begin
      for (int b = 0; b < 3; b++) begin
        o = run_biquad(b, x);
        energy[1+b] = add48(energy[1+b], o * o);
      end
    end
    if (!lst && n_samples < MAX_CHUNK_SAMPLES) return 1'b0;
    if (n_samples <= 1) begin
      clear_chunk();
      return 1'b0;
    end
    rms = int_sqrt(energy[0] / n_samples);
    zcr = (crossings << 15) / n_samples;
    opn = sat_one((rms * gain_field(0)) >>> 8);
    f.open_target = opn[15:0];
    f.wide_target = 16'(sat_one((zcr * gain_field(16)) >>> 8));
    if (bands_on) begin
      lo = int_sqrt(energy[1] / n_samples);
      mid = int_sqrt(energy[2] / n_samples);
      hi = int_sqrt(energy[3] / n_samples);
      tot = lo + mid + hi;
      lr = (tot != 0) ? (lo << 15) / tot : 0;
      hr = (tot != 0) ? (hi << 15) / tot : 0;
      f.funnel_target = 16'((shape_ratio(lr, gain_field(32)) * opn) >>> 15);
      f.fricative_target =
        16'((shape_ratio(hr, gain_field(48)) * sat_one(rms * 12)) >>> 15);
      jump = rms - slow_level;
      f.plosive_onset = (slow_level < longint'(thresh_word[15:0])) &&
                        (jump > longint'(thresh_word[31:16]));
      slow_level = (slow_level + ((jump * 4915) >>> 15)) & 64'hFFFF;
    end
    clear_chunk();
    return 1'b1;
  endfunction

  // receiver: stall pattern set by ready_mode, plus long holds on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      f_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (ready_mode)
        0: f_if.ready <= 1'b1;
        1: f_if.ready <= ($urandom_range(0, 1) == 1);
        default: f_if.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    feature_t want;
    feature_t got;
    if (!rst && f_if.valid && f_if.ready) begin
      got = '{f_if.open_target, f_if.wide_target, f_if.funnel_target,
              f_if.fricative_target, f_if.plosive_onset};
      if (feature_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = feature_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: exp open %0d wide %0d fun %0d fric %0d ons %0d,",
                      " got open %0d wide %0d fun %0d fric %0d ons %0d"},
                     want.open_target, want.wide_target, want.funnel_target,
                     want.fricative_target, want.plosive_onset, got.open_target,
                     got.wide_target, got.funnel_target, got.fricative_target,
                     got.plosive_onset);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
    @(negedge clk);
    c_if.valid = 1'b1;
    c_if.index = idx;
    c_if.data = d;
    do @(posedge clk); while (!c_if.ready);
    apply_reg(idx, d);
    @(negedge clk);
    c_if.valid = 1'b0;
  endtask

  // offer one sample; if bursty, gaps fall between random-length bursts
  task automatic send_sample(logic signed [15:0] smp, logic lst, logic bursty,
                             logic typed, feature_t typed_want);
    feature_t f;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      @(negedge clk);
      s_if.valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    burst_left = (burst_left > 0) ? burst_left - 1 : 0;
    @(negedge clk);
    s_if.valid = 1'b1;
    s_if.sample = smp;
    s_if.last_in_chunk = lst;
    do @(posedge clk); while (!s_if.ready);
    if (chunk_features(smp, lst, f)) feature_q.push_back(typed ? typed_want : f);
  endtask

  task automatic settle();
    @(negedge clk);
    s_if.valid = 1'b0;
    wait (feature_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      2: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  function automatic logic [63:0] rand_coefs(int p);
    logic [15:0] b0, a1, a2;
    if (p % 4 == 3) return {$urandom, $urandom};
    b0 = 16'($signed($urandom_range(0, 8192)) - 4096);
    a1 = 16'($signed($urandom_range(0, 32768)) - 16384);
    a2 = 16'($urandom_range(8000, 16000));
    return {16'($urandom), a2, a1, b0};
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(64, 4096));
    endcase
  endfunction

  stim_row_t directed[12] = '{
    '{16'sh7FFF, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b1, 1'b1, '0},
    '{16'sd5,    1'b1, 1'b0, '0},   // one-sample chunk, no result
    '{16'sd0,    1'b0, 1'b0, '0},
    '{16'sd0,    1'b1, 1'b1, '0},
    '{-16'sd1,   1'b0, 1'b0, '0},
    '{16'sd1,    1'b0, 1'b0, '0},
    '{-16'sd1,   1'b1, 1'b1, '0},
    '{16'sh7FFF, 1'b0, 1'b0, '0},
    '{16'sh7FFF, 1'b1, 1'b1, '0},
    '{16'sh8000, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b1, 1'b1, '0}
  };

  initial begin
    int chunk_len;
    logic [63:0] g;
    s_if.valid = 1'b0;
    s_if.sample = '0;
    s_if.last_in_chunk = 1'b0;
    c_if.valid = 1'b0;
    c_if.index = '0;
    c_if.data = '0;
    f_if.ready = 1'b0;
    for (int i = 0; i < 3; i++) band_coef[i] = '0;
    gain_word = '0;
    thresh_word = '0;
    bands_on = 1'b1;
    for (int i = 0; i < 6; i++) delay_line[i] = 0;
    slow_level = 0;
    clear_chunk();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: zero gains and thresholds give all-zero features
    foreach (directed[i])
      send_sample(directed[i].smp, directed[i].lst, 1'b0, directed[i].typed,
                  directed[i].want);
    settle();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(REG_UNUSED + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);

    for (int p = 0; p < 5; p++) begin
      ready_mode = p % 3;
      if (p == 0) begin
        for (int b = 0; b < 3; b++)
          write_reg(b[CFG_IDX_W-1:0], 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_THRESH, 64'hFFFF_FFFF);
      end else begin
        for (int b = 0; b < 3; b++) write_reg(b[CFG_IDX_W-1:0], rand_coefs(p));
        g = {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
        write_reg(REG_GAINS, g);
        write_reg(REG_THRESH, (p == 1) ? 64'h0 :
                  {32'($urandom), 16'($urandom_range(0, 4000)),
                   16'($urandom_range(2000, 65535))});
      end
      write_reg(REG_MULTI_EN, {$urandom, 31'($urandom), (p != 2)});
      for (int k = 0; k < 250; k += chunk_len) begin
        chunk_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
        for (int j = 0; j < chunk_len; j++) begin
          // hold the receiver off once while the sender keeps offering
          if (p == 3 && k >= 40 && j == 0 && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_cycles = 4000;
          end
          send_sample(rand_sample(), j == chunk_len - 1, 1'b1, 1'b0, '0);
        end
      end
      settle();
    end

    if (err_cnt == 0 && feature_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
